// ----- rtl/core/hslhp_pkg.sv -----
// Package for the HTTP status line and header parser.
// Holds the phase encoding, byte constants and the result record.
// No dependencies.
package hslhp_pkg;

    // Parse phases, one-hot.
    typedef enum logic [10:0] {
        PH_PREFIX = 11'b000_0000_0001,
        PH_MAJOR  = 11'b000_0000_0010,
        PH_DOT    = 11'b000_0000_0100,
        PH_MINOR  = 11'b000_0000_1000,
        PH_SP1    = 11'b000_0001_0000,
        PH_CODE0  = 11'b000_0010_0000,
        PH_CODE   = 11'b000_0100_0000,
        PH_TEXT   = 11'b000_1000_0000,
        PH_HDR    = 11'b001_0000_0000,
        PH_BODY   = 11'b010_0000_0000,
        PH_ERROR  = 11'b100_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] PREFIX_LAST = 3'd4;

    // Expected byte of the "HTTP/" prefix at a given position.
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                3'd0:    c = 8'h48;
                3'd1:    c = 8'h54;
                3'd2:    c = 8'h54;
                3'd3:    c = 8'h50;
                3'd4:    c = 8'h2F;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    typedef struct packed {
        t_status     parse_status;
        logic        minor_version;
        logic [15:0] status_code;
        logic [15:0] text_offset;
        logic [15:0] text_length;
        logic [15:0] header_length;
        logic [15:0] body_length;
    } t_result;

endpackage

// ----- rtl/core/hslhp_parser.sv -----
// Parse state and per-byte next-state logic of the HTTP status line parser.
// Takes one registered byte per step and emits the result record on the last byte.
// Depends on hslhp_pkg.
module hslhp_parser #(
    parameter int OFFSET_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output logic               o_res_valid,
    output hslhp_pkg::t_result o_res
);
    import hslhp_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam logic [OB-1:0] POS_MAX = '1;

    t_phase        r_phase,     n_phase;
    logic          r_cr,        n_cr;
    logic [OB-1:0] r_pos,       n_pos;
    logic          r_ver,       n_ver;
    logic [15:0]   r_code,      n_code;
    logic [OB-1:0] r_tbeg,      n_tbeg;
    logic [OB-1:0] r_tsize,     n_tsize;
    logic [1:0]    r_tmatch,    n_tmatch;
    logic [OB-1:0] r_hend,      n_hend;

    logic          w_digit;
    logic [19:0]   w_code_sum;
    logic [OB-1:0] w_cr_at;
    logic [OB:0]   w_body_start;
    logic [OB:0]   w_pos_ext;
    logic [OB-1:0] w_body_len;
    logic [OB+15:0] w_ext_tbeg, w_ext_tsize, w_ext_hend, w_ext_body;

    always_comb begin
        n_phase  = r_phase;
        n_cr     = r_cr;
        n_ver    = r_ver;
        n_code   = r_code;
        n_tbeg   = r_tbeg;
        n_tsize  = r_tsize;
        n_tmatch = r_tmatch;
        n_hend   = r_hend;
        n_pos    = (r_pos != POS_MAX) ? r_pos + OB'(1) : POS_MAX;

        w_digit    = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        w_code_sum = ({4'b0, r_code} << 3) + ({4'b0, r_code} << 1) + {16'b0, i_byte[3:0]};
        w_cr_at    = (r_pos != '0) ? r_pos - OB'(1) : '0;

        case (r_phase)
            PH_PREFIX: begin
                if ((r_pos > OB'(PREFIX_LAST)) || (i_byte != prefix_char(r_pos[2:0]))) begin
                    n_phase = PH_ERROR;
                end else if (r_pos == OB'(PREFIX_LAST)) begin
                    n_phase = PH_MAJOR;
                end
            end
            PH_MAJOR: n_phase = (i_byte == CH_ONE) ? PH_DOT : PH_ERROR;
            PH_DOT:   n_phase = (i_byte == CH_DOT) ? PH_MINOR : PH_ERROR;
            PH_MINOR: begin
                n_ver   = (i_byte == CH_ONE);
                n_phase = PH_SP1;
            end
            PH_SP1:   n_phase = (i_byte == CH_SPACE) ? PH_CODE0 : PH_ERROR;
            PH_CODE0, PH_CODE: begin
                if (w_digit) begin
                    n_code  = (w_code_sum > 20'd65535) ? 16'hFFFF : w_code_sum[15:0];
                    n_phase = PH_CODE;
                end else if ((r_phase == PH_CODE) && (i_byte == CH_SPACE)) begin
                    n_tbeg  = n_pos;
                    n_cr    = 1'b0;
                    n_phase = PH_TEXT;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_TEXT: begin
                if (r_cr && (i_byte == CH_LF)) begin
                    n_tsize  = (w_cr_at > r_tbeg) ? w_cr_at - r_tbeg : '0;
                    n_cr     = 1'b0;
                    n_tmatch = 2'd2;
                    n_phase  = PH_HDR;
                end else begin
                    n_cr = (i_byte == CH_CR);
                end
            end
            PH_HDR: begin
                // The search starts at the CR of the status line, so the match
                // count is already two when the header block begins.
                if (!r_tmatch[0]) begin
                    n_tmatch = (i_byte == CH_CR) ? r_tmatch + 2'd1 : 2'd0;
                end else if (i_byte == CH_LF) begin
                    if (r_tmatch == 2'd3) begin
                        n_hend   = (r_pos >= OB'(3)) ? r_pos - OB'(3) : '0;
                        n_phase  = PH_BODY;
                        n_tmatch = 2'd0;
                    end else begin
                        n_tmatch = 2'd2;
                    end
                end else begin
                    n_tmatch = (i_byte == CH_CR) ? 2'd1 : 2'd0;
                end
            end
            default: ;
        endcase

        w_body_start = {1'b0, n_hend} + (OB+1)'(4);
        w_pos_ext    = {1'b0, n_pos};
        w_body_len   = (w_pos_ext > w_body_start) ? OB'(w_pos_ext - w_body_start) : '0;

        // Widen first so the 16-bit slice works for any offset width.
        w_ext_tbeg  = {16'b0, n_tbeg};
        w_ext_tsize = {16'b0, n_tsize};
        w_ext_hend  = {16'b0, n_hend};
        w_ext_body  = {16'b0, w_body_len};

        o_res = '0;
        if (n_phase == PH_BODY) begin
            o_res.parse_status  = ST_OK;
            o_res.minor_version = n_ver;
            o_res.status_code   = n_code;
            o_res.text_offset   = w_ext_tbeg[15:0];
            o_res.text_length   = w_ext_tsize[15:0];
            o_res.header_length = w_ext_hend[15:0];
            o_res.body_length   = w_ext_body[15:0];
        end else if (n_phase == PH_ERROR) begin
            o_res.parse_status = ST_MALFORMED;
        end else begin
            o_res.parse_status = ST_TRUNCATED;
        end
        o_res_valid = i_step && i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase  <= PH_PREFIX;
            r_cr     <= 1'b0;
            r_pos    <= '0;
            r_ver    <= 1'b0;
            r_code   <= '0;
            r_tbeg   <= '0;
            r_tsize  <= '0;
            r_tmatch <= '0;
            r_hend   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cr     <= n_cr;
            r_pos    <= n_pos;
            r_ver    <= n_ver;
            r_code   <= n_code;
            r_tbeg   <= n_tbeg;
            r_tsize  <= n_tsize;
            r_tmatch <= n_tmatch;
            r_hend   <= n_hend;
        end
    end

endmodule

// ----- rtl/core/http_status_line_header_parser.sv -----
// Top level of the HTTP response status line and header boundary parser.
// Input byte register, parse state, and result register with handshakes.
// Depends on hslhp_pkg and hslhp_parser.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+------------------------------------------
//  input    | i_valid  | o_stall  | i_resp_byte, i_is_final_byte
//  result   | o_valid  | i_stall  | o_parse_status ... o_body_length
//
// One byte is accepted per cycle while o_stall is low. An accepted byte is held in
// the input register; when it leaves, the parse state updates and, for a final byte,
// the result register loads and o_valid rises from that register.
// Reset returns the parser to the prefix phase. A held result stalls only a
// final byte waiting in the input register; other bytes keep flowing.
module http_status_line_header_parser #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_resp_byte,
    input  logic        i_is_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_parse_status,
    output logic        o_minor_version,
    output logic [15:0] o_status_code,
    output logic [15:0] o_text_offset,
    output logic [15:0] o_text_length,
    output logic [15:0] o_header_length,
    output logic [15:0] o_body_length
);
    import hslhp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_free;
    logic       w_advance;
    logic       w_in_take;
    logic       w_res_valid;
    t_result    w_res;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = r_in_valid && (!r_in_last || w_out_free);
    assign o_stall    = r_in_valid && !w_advance;
    assign w_in_take  = i_valid && !o_stall;

    hslhp_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_resp_byte;
            r_in_last <= i_is_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_parse_status  = r_out.parse_status;
    assign o_minor_version = r_out.minor_version;
    assign o_status_code   = r_out.status_code;
    assign o_text_offset   = r_out.text_offset;
    assign o_text_length   = r_out.text_length;
    assign o_header_length = r_out.header_length;
    assign o_body_length   = r_out.body_length;

endmodule

// ----- tb/http_status_line_header_parser_checker.sv -----
`timescale 1ns / 100ps
// Checker for the HTTP status line and header parser: follows both channels,
// tracks the parse of each response and compares every result. Depends on hslhp_pkg.
module http_status_line_header_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_resp_byte,
    input  logic        i_is_final_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_parse_status,
    input  logic        i_minor_version,
    input  logic [15:0] i_status_code,
    input  logic [15:0] i_text_offset,
    input  logic [15:0] i_text_length,
    input  logic [15:0] i_header_length,
    input  logic [15:0] i_body_length,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_checked
);
    import hslhp_pkg::*;

    localparam logic [39:0] PREFIX_TEXT = "HTTP/";
    localparam logic [15:0] POS_MAX     = 16'hFFFF;

    // Parser state as seen from the byte stream.
    t_phase      phase_q;
    logic        cr_seen;
    logic [15:0] byte_idx;
    logic        minor_q;
    logic [15:0] code_q;
    logic [15:0] text_at;
    logic [15:0] text_len;
    logic [1:0]  crlf_count;
    logic [15:0] hdr_end;
    logic        malformed;

    t_result     expected_results[$];
    t_result     want;
    int          fails;
    int          checked;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    initial begin
        fails   = 0;
        checked = 0;
    end

    task automatic clear_parser();
        phase_q    = PH_PREFIX;
        cr_seen    = 1'b0;
        byte_idx   = '0;
        minor_q    = 1'b0;
        code_q     = '0;
        text_at    = '0;
        text_len   = '0;
        crlf_count = '0;
        hdr_end    = '0;
        malformed  = 1'b0;
    endtask

    task automatic mark_malformed();
        phase_q   = PH_ERROR;
        malformed = 1'b1;
    endtask

    // Advances the parse by one byte; a final byte also produces the expected result.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic [31:0] acc;
        logic [7:0]  want_ch;
        logic [15:0] cr_at;
        logic [16:0] body_start;
        logic [16:0] body_len;
        t_result     r;
        case (phase_q)
            PH_PREFIX: begin
                want_ch = (byte_idx <= 16'd4) ? PREFIX_TEXT[8 * (4 - int'(byte_idx)) +: 8] : 8'h00;
                if (byte_idx > 16'd4 || b != want_ch) mark_malformed();
                else if (byte_idx == 16'd4) phase_q = PH_MAJOR;
            end
            PH_MAJOR: begin
                if (b != CH_ONE) mark_malformed();
                else phase_q = PH_DOT;
            end
            PH_DOT: begin
                if (b != CH_DOT) mark_malformed();
                else phase_q = PH_MINOR;
            end
            PH_MINOR: begin
                minor_q = (b == CH_ONE);
                phase_q = PH_SP1;
            end
            PH_SP1: begin
                if (b != CH_SPACE) mark_malformed();
                else phase_q = PH_CODE0;
            end
            PH_CODE0, PH_CODE: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    acc     = 32'(code_q) * 32'd10 + 32'(b - CH_ZERO);
                    code_q  = (acc > 32'd65535) ? 16'hFFFF : acc[15:0];
                    phase_q = PH_CODE;
                end else if (phase_q == PH_CODE && b == CH_SPACE) begin
                    text_at = (byte_idx < POS_MAX) ? byte_idx + 16'd1 : POS_MAX;
                    cr_seen = 1'b0;
                    phase_q = PH_TEXT;
                end else begin
                    mark_malformed();
                end
            end
            PH_TEXT: begin
                if (cr_seen && b == CH_LF) begin
                    cr_at      = (byte_idx > 16'd0) ? byte_idx - 16'd1 : 16'd0;
                    text_len   = (cr_at > text_at) ? cr_at - text_at : 16'd0;
                    cr_seen    = 1'b0;
                    crlf_count = 2'd2;
                    phase_q    = PH_HDR;
                end else begin
                    cr_seen = (b == CH_CR);
                end
            end
            PH_HDR: begin
                // crlf_count counts matched bytes of CR LF CR LF; odd means a CR is pending.
                if (!crlf_count[0]) begin
                    crlf_count = (b == CH_CR) ? crlf_count + 2'd1 : 2'd0;
                end else if (b == CH_LF) begin
                    if (crlf_count == 2'd3) begin
                        hdr_end    = (byte_idx >= 16'd3) ? byte_idx - 16'd3 : 16'd0;
                        phase_q    = PH_BODY;
                        crlf_count = 2'd0;
                    end else begin
                        crlf_count = 2'd2;
                    end
                end else begin
                    crlf_count = (b == CH_CR) ? 2'd1 : 2'd0;
                end
            end
            default: ;
        endcase
        if (byte_idx != POS_MAX) byte_idx++;

        if (fin) begin
            r = '0;
            if (phase_q == PH_BODY) begin
                body_start      = {1'b0, hdr_end} + 17'd4;
                body_len        = ({1'b0, byte_idx} > body_start) ?
                                  {1'b0, byte_idx} - body_start : 17'd0;
                r.parse_status  = ST_OK;
                r.minor_version = minor_q;
                r.status_code   = code_q;
                r.text_offset   = text_at;
                r.text_length   = text_len;
                r.header_length = hdr_end;
                r.body_length   = body_len[15:0];
            end else if (phase_q == PH_ERROR || malformed) begin
                r.parse_status = ST_MALFORMED;
            end else begin
                r.parse_status = ST_TRUNCATED;
            end
            expected_results.push_back(r);
            clear_parser();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) parse_byte(i_resp_byte, i_is_final_byte);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no response outstanding");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("parse_status", 16'(want.parse_status), 16'(i_parse_status));
                    check_field("minor_version", 16'(want.minor_version),
                                16'(i_minor_version));
                    check_field("status_code", want.status_code, i_status_code);
                    check_field("text_offset", want.text_offset, i_text_offset);
                    check_field("text_length", want.text_length, i_text_length);
                    check_field("header_length", want.header_length, i_header_length);
                    check_field("body_length", want.body_length, i_body_length);
                    checked++;
                end
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the HTTP status line and header parser: builds response
// byte streams, drives both handshakes and reports the verdict.
// Depends on hslhp_pkg, http_status_line_header_parser and its checker.
module tb_top;
    import hslhp_pkg::*;

    localparam int RANDOM_BYTES = 1750;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_resp_byte;
    logic        i_is_final_byte;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_parse_status;
    logic        o_minor_version;
    logic [15:0] o_status_code;
    logic [15:0] o_text_offset;
    logic [15:0] o_text_length;
    logic [15:0] o_header_length;
    logic [15:0] o_body_length;

    int          fail_count;
    int          outstanding;
    int          checked;
    int          bytes_sent;
    int          responses_sent;
    int          cycle_count;
    int          hold_left;
    logic        quiet;
    logic        hold_go;
    logic [7:0]  resp_bytes[$];

    http_status_line_header_parser i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_resp_byte     (i_resp_byte),
        .i_is_final_byte (i_is_final_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_parse_status  (o_parse_status),
        .o_minor_version (o_minor_version),
        .o_status_code   (o_status_code),
        .o_text_offset   (o_text_offset),
        .o_text_length   (o_text_length),
        .o_header_length (o_header_length),
        .o_body_length   (o_body_length)
    );

    http_status_line_header_parser_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_resp_byte     (i_resp_byte),
        .i_is_final_byte (i_is_final_byte),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_parse_status  (o_parse_status),
        .i_minor_version (o_minor_version),
        .i_status_code   (o_status_code),
        .i_text_offset   (o_text_offset),
        .i_text_length   (o_text_length),
        .i_header_length (o_header_length),
        .i_body_length   (o_body_length),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_checked       (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped by the cycle limit with %0d results still due.", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, one long hold-off once requested, no random stalls while quiet.
    initial begin
        hold_left = HOLD_CYCLES;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 32);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!quiet && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_resp_byte     <= b;
        i_is_final_byte <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_response();
        foreach (resp_bytes[k]) send_byte(resp_bytes[k], k == resp_bytes.size() - 1);
        responses_sent++;
    endtask

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++) resp_bytes.push_back(s[k]);
    endtask

    task automatic send_text(input string s);
        resp_bytes.delete();
        add_str(s);
        send_response();
    endtask

    // Sender goes quiet until every result due so far has been taken.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Mostly printable, with stray CR, LF and arbitrary bytes mixed in.
    function automatic logic [7:0] text_char();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) return CH_CR;
        if (pick == 1) return CH_LF;
        if (pick == 2) return 8'($urandom_range(255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic build_good();
        int n;
        resp_bytes.delete();
        add_str("HTTP/1.");
        case ($urandom_range(3))
            0:       resp_bytes.push_back(8'($urandom_range(255)));
            1:       resp_bytes.push_back(CH_ZERO);
            default: resp_bytes.push_back(CH_ONE);
        endcase
        resp_bytes.push_back(CH_SPACE);
        n = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        repeat (n) resp_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
        resp_bytes.push_back(CH_SPACE);
        repeat ($urandom_range(10)) resp_bytes.push_back(text_char());
        add_str("\r\n");
        repeat ($urandom_range(2)) begin
            repeat ($urandom_range(1, 5)) resp_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
            add_str(": ");
            repeat ($urandom_range(6)) resp_bytes.push_back(text_char());
            add_str("\r\n");
        end
        add_str("\r\n");
        repeat ($urandom_range(8)) resp_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Mostly well-formed responses; the rest are cut short, corrupted or plain noise.
    task automatic build_random();
        int pick;
        int cut;
        int limit;
        pick = $urandom_range(99);
        if (pick < 8) begin
            resp_bytes.delete();
            if ($urandom_range(1)) add_str("HTTP/1.1 ");
            repeat ($urandom_range(1, 8)) resp_bytes.push_back(8'($urandom_range(255)));
        end else begin
            build_good();
            if (pick < 20) begin
                cut = $urandom_range(1, resp_bytes.size() - 1);
                while (resp_bytes.size() > cut) void'(resp_bytes.pop_back());
            end else if (pick < 32) begin
                limit = (resp_bytes.size() > 16) ? 15 : resp_bytes.size() - 1;
                resp_bytes[$urandom_range(limit)] = 8'($urandom_range(255));
            end
        end
    endtask

    initial begin
        int n_resp;
        int random_bytes;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_resp_byte     <= 8'h00;
        i_is_final_byte <= 1'b0;
        quiet          = 1'b0;
        hold_go        = 1'b0;
        bytes_sent     = 0;
        responses_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("HTTP/1.1 200 OK\r\n\r\nab");
        send_text("HTTP/1.0 404 Not Found\r\nA: b\r\n\r\n");
        send_text("HTTP/1.x 99999 Big\r\n\r\n");
        send_text("HTTX/1.1 200 OK\r\n\r\n");
        send_text("HTTP/2.0 200 OK\r\n\r\n");
        send_text("HTTP/1.1 200\r\n\r\n");
        send_text("HTTP/1.1  200 X\r\n\r\n");
        send_text("HTTP/1.1 2a0 X\r\n\r\n");
        send_text("HTTP/1.1 200 OK");
        send_text("HTTP/1.1 200 OK\r\nA: b\r\n");
        send_text("HTTP/1.1 200 O\rK\r\n\r\n");
        send_text("HTTP/1.1 204 \r\n\r\n");
        send_text("H");
        resp_bytes.delete();
        resp_bytes.push_back(8'hFF);
        send_response();
        drain();

        n_resp       = 0;
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            if (n_resp == 10) hold_go = 1'b1;
            quiet = (n_resp >= 25 && n_resp < 33);
            if (n_resp == 18) drain();
            build_random();
            random_bytes += resp_bytes.size();
            send_response();
            n_resp++;
        end
        drain();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d responses in %0d bytes; %0d results compared.",
                 responses_sent, bytes_sent, checked);
        $display("Mix: well-formed, malformed, truncated, noise, long hold-off, quiet run.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
